// ===== rtl/core/tdr_pkg.sv =====
// Shared types and constants for the tap dance resolver.
package tdr_pkg;
    localparam int unsigned DEFAULT_TERM = 200;
    localparam int unsigned LEN_W = 3;
    localparam int unsigned TERM_W = 10;

    typedef enum logic [1:0] {
        MODE_PRESS   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_OTHER   = 2'd2,
        MODE_TICK    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    localparam int unsigned CFG_ENABLE  = 0;
    localparam int unsigned CFG_LENGTHS = 1;
    localparam int unsigned CFG_TERMS   = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_position;
        logic [1:0] out_slot;
        logic [1:0] tap_index;
        logic       last;
    } t_result;

    // Controller to datapath.
    typedef struct packed {
        logic load;  // capture input item
        logic step;  // process current entry
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic busy;     // scan or emission pending
        logic res_vld;  // result available this cycle
    } t_sts;
endpackage

// ===== rtl/core/tdr_stream_if.sv =====
// Valid/ready channel interface carrying a generic payload.
interface tdr_stream_if #(
    parameter int unsigned W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tap_dance_resolver_core.sv =====
// Top level of the tap dance resolver: config registers, controller, datapath.
// An item is captured, then for other-key and tick items the entries are
// scanned one per cycle unless a result waits on a stalled output, with an
// extra step for an entry that also owes a release. Press and release items
// are handled without a scan.
// One item is handled at a time. Reset is synchronous and active low; it
// frees all entries, stops all timers and restores the register defaults.
module tap_dance_resolver_core
    import tdr_pkg::*;
#(
    parameter int unsigned SLOTS   = 4,
    parameter int unsigned TAPS    = 4,
    parameter int unsigned ENTRIES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdr_stream_if.sink   in_if,
    tdr_stream_if.source out_if,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [39:0] i_cfg_data
);
    // Input transaction: {mode, slot, key_position}; output: t_result.
    logic                    r_enable;
    logic [SLOTS*LEN_W-1:0]  r_lengths;
    logic [SLOTS*TERM_W-1:0] r_terms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_lengths <= '0;
            r_terms <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 2'(CFG_ENABLE)) r_enable <= i_cfg_data[0];
            if (i_cfg_index == 2'(CFG_LENGTHS)) r_lengths <= i_cfg_data[SLOTS*LEN_W-1:0];
            if (i_cfg_index == 2'(CFG_TERMS)) r_terms <= i_cfg_data[SLOTS*TERM_W-1:0];
        end
    end

    t_cmd    cmd;
    t_sts    sts;
    t_result res;

    tdr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_if.valid), .o_in_ready(in_if.ready),
        .i_out_ready(out_if.ready), .i_sts(sts), .o_cmd(cmd)
    );

    tdr_datapath #(.SLOTS(SLOTS), .TAPS(TAPS), .ENTRIES(ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_mode(in_if.data[11:10]), .i_slot(in_if.data[9:8]),
        .i_key_position(in_if.data[7:0]),
        .i_enable(r_enable), .i_lengths(r_lengths), .i_terms(r_terms),
        .o_sts(sts), .o_res(res)
    );

    // Results are shown combinationally while the scan holds on the entry;
    // valid stays up through an output stall since the scan does not move.
    assign out_if.valid = sts.res_vld;
    assign out_if.data = res;
endmodule

// ===== rtl/core/tdr_ctrl.sv =====
// Controller state machine: sequences input capture and entry scan.
module tdr_ctrl
    import tdr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                // Hold while a result waits on a stalled sink.
                o_cmd.step = !(i_sts.res_vld && !i_out_ready);
                if (!i_sts.busy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end
endmodule

// ===== rtl/core/tdr_datapath.sv =====
// Entry table and per-entry step logic of the tap dance resolver.
module tdr_datapath
    import tdr_pkg::*;
#(
    parameter int unsigned SLOTS   = 4,
    parameter int unsigned TAPS    = 4,
    parameter int unsigned ENTRIES = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [1:0]              i_mode,
    input  logic [1:0]              i_slot,
    input  logic [7:0]              i_key_position,
    input  logic                    i_enable,
    input  logic [SLOTS*LEN_W-1:0]  i_lengths,
    input  logic [SLOTS*TERM_W-1:0] i_terms,
    output t_sts                    o_sts,
    output t_result                 o_res
);
    localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0] r_used, r_down, r_resd;
    logic [7:0]         r_pos  [ENTRIES];
    logic [1:0]         r_eslot[ENTRIES];
    logic [2:0]         r_cnt  [ENTRIES];
    logic [TERM_W-1:0]  r_term [ENTRIES];
    logic [1:0]         r_fidx [ENTRIES];

    logic [1:0] r_mode, r_islot;
    logic [7:0] r_ipos;
    logic [CW-1:0] r_idx;     // scan index, ENTRIES means done
    logic       r_rel_pend;   // release still owed for current entry
    logic       r_done;
    logic [3:0] r_nres;       // results emitted so far, max 8

    function automatic logic [2:0] tap_len(input logic [1:0] s,
                                           input logic [SLOTS*LEN_W-1:0] l);
        logic [2:0] v;
        v = '0;
        for (int k = 0; k < SLOTS; k++)
            if (int'(s) == k) v = l[k*LEN_W +: LEN_W];
        if (int'(s) >= SLOTS) v = '0;
        return (int'(v) > TAPS) ? 3'(TAPS) : v;
    endfunction

    function automatic logic [TERM_W-1:0] slot_term(input logic [1:0] s,
                                                    input logic [SLOTS*TERM_W-1:0] t);
        logic [TERM_W-1:0] v;
        v = '0;
        for (int k = 0; k < SLOTS; k++)
            if (int'(s) == k) v = t[k*TERM_W +: TERM_W];
        return (v == '0) ? TERM_W'(DEFAULT_TERM) : v;
    endfunction

    // Press lookup: matching entry, else first free entry.
    logic          hit, free;
    logic [EW-1:0] hit_e, free_e, pe;
    always_comb begin
        hit = 1'b0; free = 1'b0; hit_e = '0; free_e = '0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (r_used[k] && r_pos[k] == r_ipos) begin hit = 1'b1; hit_e = EW'(k); end
            if (!r_used[k]) begin free = 1'b1; free_e = EW'(k); end
        end
        pe = hit ? hit_e : free_e;
    end

    logic [EW-1:0] ce;
    assign ce = r_idx[EW-1:0];
    logic at_end;
    assign at_end = (r_idx >= CW'(ENTRIES));

    logic [2:0] plen, elen, pcnt, mlen;
    assign plen = tap_len(r_islot, i_lengths);
    assign elen = tap_len(r_eslot[ce], i_lengths);
    assign pcnt = r_cnt[ce];
    assign mlen = (pcnt < elen) ? pcnt : elen;
    logic [1:0] fidx;
    assign fidx = (mlen != 0) ? 2'(mlen - 3'd1) : 2'd0;

    // Press update: new tap count, and the decision when it reaches the length.
    // The chosen index follows the entry's own slot.
    logic [2:0] p_cnt, p_ncnt, p_elen, p_m;
    logic [1:0] p_eslot, p_fidx;
    logic       p_fire;
    assign p_eslot = hit ? r_eslot[pe] : r_islot;
    assign p_cnt = hit ? r_cnt[pe] : 3'd0;
    assign p_ncnt = (p_cnt < plen) ? p_cnt + 3'd1 : p_cnt;
    assign p_fire = (p_ncnt == plen);
    assign p_elen = tap_len(p_eslot, i_lengths);
    assign p_m = (p_ncnt < p_elen) ? p_ncnt : p_elen;
    assign p_fidx = (p_m != 0) ? 2'(p_m - 3'd1) : 2'd0;

    // Release path for mode 1 also needs the match; handled by scanning the
    // whole table for the match when mode is release.
    logic          rhit;
    logic [EW-1:0] rhit_e;
    always_comb begin
        rhit = 1'b0; rhit_e = '0;
        for (int k = ENTRIES - 1; k >= 0; k--)
            if (r_used[k] && r_pos[k] == r_ipos) begin rhit = 1'b1; rhit_e = EW'(k); end
    end

    // Per-step decision for the current entry.
    logic    emit, rel_next;
    t_result res;
    always_comb begin
        emit = 1'b0; rel_next = 1'b0;
        res = '0;
        res.out_position = r_pos[ce];
        res.out_slot = r_eslot[ce];
        if (r_rel_pend) begin
            emit = 1'b1;
            res.kind = KIND_RELEASE;
            res.tap_index = r_fidx[ce];
        end else if (!at_end && !r_done) begin
            unique case (t_mode'(r_mode))
                MODE_PRESS: begin
                    if (i_enable && plen != 0) begin
                        if (!hit && !free) begin
                            emit = 1'b1;
                            res.kind = KIND_ERROR;
                            res.out_position = r_ipos;
                            res.out_slot = r_islot;
                        end else if (p_fire) begin
                            emit = 1'b1;
                            res.kind = KIND_PRESS;
                            res.out_position = r_ipos;
                            res.out_slot = p_eslot;
                            res.tap_index = p_fidx;
                        end
                    end
                end
                MODE_RELEASE: begin
                    if (rhit && r_resd[rhit_e]) begin
                        emit = 1'b1;
                        res.kind = KIND_RELEASE;
                        res.tap_index = r_fidx[rhit_e];
                    end
                end
                MODE_OTHER: begin
                    if (r_used[ce] && r_pos[ce] != r_ipos && !r_resd[ce]) begin
                        emit = 1'b1;
                        res.kind = KIND_PRESS;
                        res.tap_index = fidx;
                        rel_next = !r_down[ce];
                    end
                end
                MODE_TICK: begin
                    if (r_used[ce] && r_term[ce] == TERM_W'(1)) begin
                        emit = 1'b1;
                        res.kind = KIND_PRESS;
                        res.tap_index = fidx;
                        rel_next = !r_down[ce];
                    end
                end
                default: ;
            endcase
        end
    end

    logic room;
    assign room = (r_nres < 4'd8);
    logic busy;
    assign busy = r_rel_pend || (!at_end && !r_done);
    // Last flag: lookahead on later entries; forced on the eighth result and for a release item.
    logic later;
    always_comb begin
        later = 1'b0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (CW'(k) > r_idx && r_used[k]) begin
                if (t_mode'(r_mode) == MODE_OTHER && r_pos[k] != r_ipos && !r_resd[k])
                    later = 1'b1;
                if (t_mode'(r_mode) == MODE_TICK && r_term[k] == TERM_W'(1))
                    later = 1'b1;
            end
        end
    end
    logic more;
    assign more = r_rel_pend ? later : (rel_next || later);
    logic last_flag;
    assign last_flag = !more || (r_nres == 4'd7);

    assign o_sts.busy = busy;
    assign o_sts.res_vld = emit && room;
    always_comb begin
        o_res = res;
        o_res.last = last_flag;
        if (t_mode'(r_mode) == MODE_RELEASE && !r_rel_pend) begin
            o_res.out_position = r_pos[rhit_e];
            o_res.out_slot = r_eslot[rhit_e];
            o_res.tap_index = r_fidx[rhit_e];
            o_res.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_idx <= CW'(ENTRIES);
            r_rel_pend <= 1'b0;
            r_done <= 1'b1;
            r_nres <= '0;
            for (int k = 0; k < ENTRIES; k++) r_term[k] <= '0;
        end else if (i_cmd.load) begin
            r_mode <= i_mode;
            r_islot <= i_slot;
            r_ipos <= i_key_position;
            r_idx <= '0;
            r_done <= 1'b0;
            r_rel_pend <= 1'b0;
            r_nres <= '0;
        end else if (i_cmd.step && busy) begin
            if (emit && room) r_nres <= r_nres + 4'd1;
            if (r_rel_pend) begin
                r_used[ce] <= 1'b0;
                r_term[ce] <= '0;
                r_rel_pend <= 1'b0;
                r_idx <= r_idx + CW'(1);
            end else begin
                unique case (t_mode'(r_mode))
                    MODE_PRESS: begin
                        r_done <= 1'b1;
                        if (i_enable && plen != 0 && (hit || free)) begin
                            if (!hit) begin
                                r_used[pe] <= 1'b1;
                                r_pos[pe] <= r_ipos;
                                r_eslot[pe] <= r_islot;
                            end
                            r_down[pe] <= 1'b1;
                            r_cnt[pe] <= p_ncnt;
                            if (p_fire) begin
                                r_term[pe] <= '0;
                                r_resd[pe] <= 1'b1;
                                r_fidx[pe] <= p_fidx;
                            end else begin
                                r_term[pe] <= slot_term(r_islot, i_terms);
                                if (!hit) r_resd[pe] <= 1'b0;
                            end
                        end
                    end
                    MODE_RELEASE: begin
                        r_done <= 1'b1;
                        if (rhit) begin
                            r_down[rhit_e] <= 1'b0;
                            if (r_resd[rhit_e]) begin
                                r_used[rhit_e] <= 1'b0;
                                r_term[rhit_e] <= '0;
                            end
                        end
                    end
                    MODE_OTHER: begin
                        if (r_used[ce] && r_pos[ce] != r_ipos) begin
                            r_term[ce] <= '0;
                            if (!r_resd[ce]) begin
                                r_resd[ce] <= 1'b1;
                                r_fidx[ce] <= fidx;
                            end
                        end
                        if (rel_next) r_rel_pend <= 1'b1;
                        else r_idx <= r_idx + CW'(1);
                    end
                    MODE_TICK: begin
                        if (r_used[ce] && r_term[ce] != '0) begin
                            r_term[ce] <= r_term[ce] - TERM_W'(1);
                            if (r_term[ce] == TERM_W'(1)) begin
                                r_resd[ce] <= 1'b1;
                                r_fidx[ce] <= fidx;
                            end
                        end
                        if (rel_next) r_rel_pend <= 1'b1;
                        else r_idx <= r_idx + CW'(1);
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== test/tdr_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the tap dance resolver: predicts every result and compares it.
module tdr_checker
    import tdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdr_stream_if       in_ch,
    tdr_stream_if       out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [39:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    localparam int NE = 4;

    logic        cfg_enable;
    logic [11:0] cfg_lengths;
    logic [39:0] cfg_terms;

    logic       dn_used  [NE];
    logic [7:0] dn_pos   [NE];
    logic [1:0] dn_slot  [NE];
    logic [2:0] dn_taps  [NE];
    logic       dn_down  [NE];
    logic       dn_done  [NE];
    logic [9:0] dn_left  [NE];
    logic [1:0] dn_fired [NE];

    t_result chosen_q[$];
    t_result burst[8];
    int      burst_n;

    function automatic int unsigned taps_for(logic [1:0] s);
        int unsigned v;
        v = cfg_lengths[3*s +: 3];
        return (v > 4) ? 4 : v;
    endfunction

    function automatic logic [9:0] term_for(logic [1:0] s);
        logic [9:0] v;
        v = cfg_terms[10*s +: 10];
        return (v == 0) ? 10'(DEFAULT_TERM) : v;
    endfunction

    task automatic push(t_kind k, logic [7:0] p, logic [1:0] s, logic [1:0] ix);
        if (burst_n < 8) begin
            burst[burst_n] = '{kind: k, out_position: p, out_slot: s, tap_index: ix, last: 1'b0};
            burst_n++;
        end
    endtask

    task automatic decide(int e);
        int unsigned len;
        int unsigned m;
        len = taps_for(dn_slot[e]);
        m = (dn_taps[e] < len) ? dn_taps[e] : len;
        dn_done[e] = 1'b1;
        dn_fired[e] = (m != 0) ? 2'(m - 1) : 2'd0;
        push(KIND_PRESS, dn_pos[e], dn_slot[e], dn_fired[e]);
    endtask

    task automatic let_go(int e);
        push(KIND_RELEASE, dn_pos[e], dn_slot[e], dn_fired[e]);
        dn_used[e] = 1'b0;
        dn_left[e] = '0;
    endtask

    task automatic predict_item(logic [1:0] mode, logic [1:0] slot, logic [7:0] pos);
        int e;
        int unsigned len;
        burst_n = 0;
        case (t_mode'(mode))
            MODE_PRESS: begin
                len = taps_for(slot);
                if (cfg_enable && len != 0) begin
                    e = -1;
                    for (int i = 0; i < NE; i++)
                        if (e < 0 && dn_used[i] && dn_pos[i] == pos) e = i;
                    if (e < 0)
                        for (int i = 0; i < NE; i++)
                            if (e < 0 && !dn_used[i]) e = i;
                    if (e < 0) begin
                        push(KIND_ERROR, pos, slot, 2'd0);
                    end else begin
                        if (!dn_used[e]) begin
                            dn_used[e] = 1'b1;
                            dn_pos[e] = pos;
                            dn_slot[e] = slot;
                            dn_taps[e] = '0;
                            dn_done[e] = 1'b0;
                        end
                        dn_down[e] = 1'b1;
                        dn_left[e] = '0;
                        if (dn_taps[e] < len) dn_taps[e]++;
                        if (dn_taps[e] == len) decide(e);
                        else dn_left[e] = term_for(slot);
                    end
                end
            end
            MODE_RELEASE: begin
                e = -1;
                for (int i = 0; i < NE; i++)
                    if (e < 0 && dn_used[i] && dn_pos[i] == pos) e = i;
                if (e >= 0) begin
                    dn_down[e] = 1'b0;
                    if (dn_done[e]) let_go(e);
                end
            end
            MODE_OTHER: begin
                for (int i = 0; i < NE; i++) begin
                    if (dn_used[i] && dn_pos[i] != pos) begin
                        dn_left[i] = '0;
                        if (!dn_done[i]) begin
                            decide(i);
                            if (!dn_down[i]) let_go(i);
                        end
                    end
                end
            end
            default: begin
                for (int i = 0; i < NE; i++) begin
                    if (dn_used[i] && dn_left[i] != 0) begin
                        dn_left[i]--;
                        if (dn_left[i] == 0) begin
                            decide(i);
                            if (!dn_down[i]) let_go(i);
                        end
                    end
                end
            end
        endcase
        if (burst_n > 0) burst[burst_n-1].last = 1'b1;
        for (int i = 0; i < burst_n; i++) chosen_q.push_back(burst[i]);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg_enable <= 1'b1;
            cfg_lengths <= '0;
            cfg_terms <= '0;
            for (int i = 0; i < NE; i++) begin
                dn_used[i] = 1'b0;
                dn_left[i] = '0;
            end
            chosen_q.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (chosen_q.size() == 0) begin
                    $error("result with nothing expected: %h", got);
                    o_errors++;
                end else begin
                    want = chosen_q.pop_front();
                    if (got.kind != want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        o_errors++;
                    end
                    if (got.out_position != want.out_position) begin
                        $error("out_position: expected %0d, got %0d",
                               want.out_position, got.out_position);
                        o_errors++;
                    end
                    if (got.out_slot != want.out_slot) begin
                        $error("out_slot: expected %0d, got %0d", want.out_slot, got.out_slot);
                        o_errors++;
                    end
                    if (got.tap_index != want.tap_index) begin
                        $error("tap_index: expected %0d, got %0d",
                               want.tap_index, got.tap_index);
                        o_errors++;
                    end
                    if (got.last != want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        o_errors++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_item(in_ch.data[11:10], in_ch.data[9:8], in_ch.data[7:0]);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    2'(CFG_ENABLE):  cfg_enable <= i_cfg_data[0];
                    2'(CFG_LENGTHS): cfg_lengths <= i_cfg_data[11:0];
                    2'(CFG_TERMS):   cfg_terms <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = chosen_q.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end
endmodule

// ===== test/tb_tap_dance_resolver_core.sv =====
`timescale 1ns / 1ps
// Testbench top for the tap dance resolver: stimulus, stalls and the verdict.
module tb_tap_dance_resolver_core;
    import tdr_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [39:0] i_cfg_data = '0;

    int errors;
    int pending;

    // When idle_on is clear, neither side inserts random gaps or stalls.
    bit idle_on = 1'b1;
    // Requests one long output hold-off so the block backs up into its input.
    bit hold_req = 1'b0;

    tdr_stream_if #(.W(12)) in_if ();
    tdr_stream_if #(.W(15)) out_if ();

    tap_dance_resolver_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_if(in_if), .out_if(out_if),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    tdr_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_if), .out_ch(out_if),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
    end

    // Output side: ready drops in random bursts, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_req = 1'b0;
                out_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Offers one transaction; called and returns at a falling edge. Valid is
    // lowered only ahead of a gap, so back-to-back items keep it high.
    task automatic send(t_mode mode, logic [1:0] slot, logic [7:0] pos);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= {mode, slot, pos};
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    // Lets the block drain: every expected result seen, then its scan latency.
    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic cfg_write(int unsigned idx, logic [39:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= 2'(idx);
        i_cfg_data <= value;
        @(negedge i_clk);
    endtask

    task automatic cfg_apply(logic en, logic [11:0] lens, logic [39:0] terms);
        cfg_write(CFG_ENABLE, {39'd0, en});
        cfg_write(CFG_LENGTHS, {28'd0, lens});
        cfg_write(CFG_TERMS, terms);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Random traffic around a small pool of dance keys: mostly taps, releases
    // and tick runs, with interrupting key presses mixed in as noise.
    task automatic random_phase(int items);
        logic [7:0] pool_pos [6];
        logic [1:0] pool_slot [6];
        int k;
        for (int i = 0; i < 6; i++) begin
            pool_pos[i] = 8'($urandom_range(0, 255));
            pool_slot[i] = 2'($urandom_range(0, 3));
        end
        for (int n = 0; n < items; n++) begin
            k = $urandom_range(0, 5);
            case ($urandom_range(0, 9))
                0, 1, 2: send(MODE_PRESS, pool_slot[k], pool_pos[k]);
                3, 4:    send(MODE_RELEASE, 2'($urandom_range(0, 3)), pool_pos[k]);
                5, 6, 7: repeat ($urandom_range(1, 4))
                             send(MODE_TICK, 2'($urandom_range(0, 3)),
                                  8'($urandom_range(0, 255)));
                8:       send(MODE_OTHER, 2'($urandom_range(0, 3)),
                              ($urandom_range(0, 1) != 0) ? pool_pos[k]
                                                          : 8'($urandom_range(0, 255)));
                default: send(MODE_PRESS, 2'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)));
            endcase
        end
        settle();
    endtask

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Slot 0 needs one tap, slot 1 two, slot 2 four, slot 3 seven which
        // saturates to four. Short terms, with slot 3 on the default term.
        cfg_apply(1'b1, {3'd7, 3'd4, 3'd2, 3'd1}, {10'd0, 10'd5, 10'd3, 10'd1});

        // Single-tap slot resolves on the press; release follows.
        send(MODE_PRESS, 2'd0, 8'd0);
        send(MODE_RELEASE, 2'd0, 8'd0);
        // Undecided release only marks the key up; the term then expires.
        send(MODE_PRESS, 2'd1, 8'd255);
        send(MODE_RELEASE, 2'd1, 8'd255);
        repeat (3) send(MODE_TICK, 2'd3, 8'd0);
        // Interrupt by another key while held.
        send(MODE_PRESS, 2'd2, 8'd10);
        send(MODE_PRESS, 2'd2, 8'd10);
        send(MODE_OTHER, 2'd0, 8'd99);
        send(MODE_RELEASE, 2'd2, 8'd10);
        // Full table, then one interrupt decides all four held dances.
        for (int p = 1; p <= 5; p++) send(MODE_PRESS, 2'd2, 8'(p));
        send(MODE_OTHER, 2'd3, 8'd200);
        for (int p = 1; p <= 4; p++) send(MODE_RELEASE, 2'd1, 8'(p));
        // An existing entry keeps its slot when pressed through another slot.
        send(MODE_PRESS, 2'd2, 8'd20);
        send(MODE_PRESS, 2'd0, 8'd20);
        send(MODE_OTHER, 2'd1, 8'd21);
        send(MODE_RELEASE, 2'd0, 8'd20);
        // A press after the decision decides again; a stray release does nothing.
        send(MODE_PRESS, 2'd0, 8'd30);
        send(MODE_PRESS, 2'd0, 8'd30);
        send(MODE_RELEASE, 2'd0, 8'd30);
        send(MODE_RELEASE, 2'd0, 8'd77);
        // Two taps held on slot 2, whose length is cut to zero before the decision.
        send(MODE_PRESS, 2'd2, 8'd50);
        send(MODE_PRESS, 2'd2, 8'd50);
        settle();
        cfg_apply(1'b1, {3'd7, 3'd0, 3'd2, 3'd1}, {10'd0, 10'd5, 10'd3, 10'd1});
        send(MODE_OTHER, 2'd0, 8'd51);
        send(MODE_RELEASE, 2'd2, 8'd50);
        // Empty slot and disabled dances both ignore presses.
        send(MODE_PRESS, 2'd2, 8'd60);
        settle();
        cfg_apply(1'b0, 12'hfff, 40'hff_ffff_ffff);
        send(MODE_PRESS, 2'd1, 8'd61);
        send(MODE_TICK, 2'd0, 8'd0);
        settle();
        // A held key on the default 200 ms term outlasts a few ticks; another
        // key then decides it.
        cfg_apply(1'b1, {3'd7, 3'd4, 3'd2, 3'd1}, {10'd0, 10'd5, 10'd3, 10'd1});
        send(MODE_PRESS, 2'd3, 8'd40);
        repeat (3) send(MODE_TICK, 2'd0, 8'd0);
        send(MODE_OTHER, 2'd0, 8'd41);
        send(MODE_RELEASE, 2'd3, 8'd40);
        settle();

        // Random phases with mostly short terms; the second opens with a long
        // output hold-off while input keeps coming.
        cfg_apply(1'b1, 12'($urandom_range(0, 4095)),
                  {10'($urandom_range(1, 6)), 10'($urandom_range(1, 6)),
                   10'($urandom_range(0, 4)), 10'($urandom_range(1, 1023))});
        random_phase(20);
        cfg_apply(1'($urandom_range(0, 3) != 0), 12'($urandom_range(0, 4095)),
                  {10'($urandom_range(1, 6)), 10'($urandom_range(1, 6)),
                   10'($urandom_range(1, 6)), 10'($urandom_range(1, 6))});
        hold_req = 1'b1;
        random_phase(20);
        cfg_apply(1'b1, 12'($urandom_range(0, 4095)),
                  {10'($urandom_range(1, 6)), 10'($urandom_range(1, 6)),
                   10'($urandom_range(1, 6)), 10'($urandom_range(1, 6))});
        idle_on = 1'b0;
        random_phase(20);

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/tdr_pkg.sv
rtl/core/tdr_stream_if.sv
rtl/core/tdr_ctrl.sv
rtl/core/tdr_datapath.sv
rtl/core/tap_dance_resolver_core.sv
test/tdr_checker.sv
test/tb_tap_dance_resolver_core.sv
